FILE: rtl/rc4_pkg.sv
// Shared types, codes and the control store for the RC4 core.
package rc4_pkg;

    localparam int KEY_MAX_DEF = 256;
    localparam int LEN_W       = 9;

    typedef enum logic [1:0] {
        MODE_KEY   = 2'd0,
        MODE_SCHED = 2'd1,
        MODE_CRYPT = 2'd2,
        MODE_NONE  = 2'd3
    } mode_t;

    typedef enum logic [3:0] {
        UPC_IDLE     = 4'd0,
        UPC_KEY_WR   = 4'd1,
        UPC_C0       = 4'd2,
        UPC_C1       = 4'd3,
        UPC_C2       = 4'd4,
        UPC_C3       = 4'd5,
        UPC_KS_INIT  = 4'd6,
        UPC_KS_FILL  = 4'd7,
        UPC_KS_RD    = 4'd8,
        UPC_KS_J     = 4'd9,
        UPC_KS_W1    = 4'd10,
        UPC_KS_W2    = 4'd11,
        UPC_KS_END   = 4'd12
    } upc_t;

    typedef enum logic [1:0] {
        RD_I       = 2'd0,
        RD_I_INC   = 2'd1,
        RD_J_SUM   = 2'd2,
        RD_A_PLUS  = 2'd3
    } rd_sel_t;

    typedef enum logic {
        WA_I = 1'b0,
        WA_J = 1'b1
    } wa_sel_t;

    typedef enum logic [1:0] {
        WD_I     = 2'd0,
        WD_RDATA = 2'd1,
        WD_A     = 2'd2
    } wd_sel_t;

    typedef enum logic [1:0] {
        I_HOLD = 2'd0,
        I_INC  = 2'd1,
        I_CLR  = 2'd2
    } i_op_t;

    typedef enum logic [1:0] {
        J_HOLD = 2'd0,
        J_SUM  = 2'd1,
        J_CLR  = 2'd2
    } j_op_t;

    typedef enum logic [1:0] {
        K_HOLD = 2'd0,
        K_CLR  = 2'd1,
        K_STEP = 2'd2
    } k_op_t;

    typedef enum logic [1:0] {
        SEQ_DISPATCH = 2'd0,
        SEQ_NEXT     = 2'd1,
        SEQ_LOOP     = 2'd2,
        SEQ_DONE     = 2'd3
    } seq_op_t;

    typedef struct packed {
        logic    perm_rd_en;
        rd_sel_t perm_rd_sel;
        logic    perm_we;
        wa_sel_t perm_wa_sel;
        wd_sel_t perm_wd_sel;
        i_op_t   i_op;
        j_op_t   j_op;
        logic    j_use_key;
        logic    a_load;
        logic    b_load;
        k_op_t   k_op;
        logic    key_we;
        logic    out_load;
        seq_op_t seq;
        upc_t    target;
    } cw_t;

    // Entry point of each mode's routine
    function automatic upc_t mode_entry(input mode_t m);
        upc_t e;
        e = UPC_IDLE;
        unique case (m)
            MODE_KEY:   e = UPC_KEY_WR;
            MODE_SCHED: e = UPC_KS_INIT;
            MODE_CRYPT: e = UPC_C0;
            MODE_NONE:  e = UPC_IDLE;
            default:    e = UPC_IDLE;
        endcase
        return e;
    endfunction

    // Control store: one control word per step
    function automatic cw_t ucode_rom(input upc_t upc);
        cw_t cw;
        cw = '0;
        cw.seq = SEQ_DONE;
        cw.target = UPC_IDLE;
        unique case (upc)
            UPC_IDLE: begin
                cw.seq = SEQ_DISPATCH;
            end
            UPC_KEY_WR: begin
                cw.key_we = 1'b1;
                cw.seq    = SEQ_DONE;
            end
            UPC_C0: begin
                cw.perm_rd_en  = 1'b1;
                cw.perm_rd_sel = RD_I_INC;
                cw.i_op        = I_INC;
                cw.seq         = SEQ_NEXT;
            end
            UPC_C1: begin
                cw.perm_rd_en  = 1'b1;
                cw.perm_rd_sel = RD_J_SUM;
                cw.j_op        = J_SUM;
                cw.a_load      = 1'b1;
                cw.seq         = SEQ_NEXT;
            end
            UPC_C2: begin
                cw.perm_rd_en  = 1'b1;
                cw.perm_rd_sel = RD_A_PLUS;
                cw.perm_we     = 1'b1;
                cw.perm_wa_sel = WA_I;
                cw.perm_wd_sel = WD_RDATA;
                cw.b_load      = 1'b1;
                cw.seq         = SEQ_NEXT;
            end
            UPC_C3: begin
                cw.perm_we     = 1'b1;
                cw.perm_wa_sel = WA_J;
                cw.perm_wd_sel = WD_A;
                cw.out_load    = 1'b1;
                cw.seq         = SEQ_DONE;
            end
            UPC_KS_INIT: begin
                cw.i_op = I_CLR;
                cw.j_op = J_CLR;
                cw.k_op = K_CLR;
                cw.seq  = SEQ_NEXT;
            end
            UPC_KS_FILL: begin
                cw.perm_we     = 1'b1;
                cw.perm_wa_sel = WA_I;
                cw.perm_wd_sel = WD_I;
                cw.i_op        = I_INC;
                cw.seq         = SEQ_LOOP;
                cw.target      = UPC_KS_FILL;
            end
            UPC_KS_RD: begin
                cw.perm_rd_en  = 1'b1;
                cw.perm_rd_sel = RD_I;
                cw.seq         = SEQ_NEXT;
            end
            UPC_KS_J: begin
                cw.perm_rd_en  = 1'b1;
                cw.perm_rd_sel = RD_J_SUM;
                cw.j_op        = J_SUM;
                cw.j_use_key   = 1'b1;
                cw.a_load      = 1'b1;
                cw.seq         = SEQ_NEXT;
            end
            UPC_KS_W1: begin
                cw.perm_we     = 1'b1;
                cw.perm_wa_sel = WA_I;
                cw.perm_wd_sel = WD_RDATA;
                cw.seq         = SEQ_NEXT;
            end
            UPC_KS_W2: begin
                cw.perm_we     = 1'b1;
                cw.perm_wa_sel = WA_J;
                cw.perm_wd_sel = WD_A;
                cw.i_op        = I_INC;
                cw.k_op        = K_STEP;
                cw.seq         = SEQ_LOOP;
                cw.target      = UPC_KS_RD;
            end
            UPC_KS_END: begin
                cw.i_op = I_CLR;
                cw.j_op = J_CLR;
                cw.seq  = SEQ_DONE;
            end
            default: begin
                cw.seq = SEQ_DONE;
            end
        endcase
        return cw;
    endfunction

endpackage

FILE: rtl/rc4_stream_cipher_core.sv
// Top level of the RC4 core: handshakes, key length register, output beat.
// Crypt beat: steps C0 to C3 from acceptance to result; the next beat is taken only back in idle,
//   the steps being the dependent read, read, read-and-write, write chain on the table's read and write ports.
// Key byte write: step UPC_KEY_WR. Key schedule: clear, 256 fill steps, 256 swaps of
//   4 steps, clear, then back to idle.
// Reset (async, active low) clears pointers, sequencer and output valid; key length resets to 1.
// Table and key store are undefined until written; run a key schedule before crypting.
module rc4_stream_cipher_core
    import rc4_pkg::*;
#(
    parameter int KEY_MAX = KEY_MAX_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [LEN_W-1:0] cfg_wr_data,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [1:0]       mode,
    input  logic [7:0]       key_index,
    input  logic [7:0]       byte_in,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [7:0]       byte_out
);

    cw_t              cw;
    logic             idle;
    logic             accept;
    logic             advance;
    logic             i_last;
    logic [7:0]       crypt_byte;
    logic [LEN_W-1:0] key_length_reg;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       byte_out_reg;

    // Take a new beat only between routines
    assign in_stall = !idle;
    assign accept   = in_valid && !in_stall;

    // Hold the result step while the previous result is still waiting downstream
    assign advance = !(cw.out_load && out_valid_reg && out_stall);

    rc4_sequencer u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .mode    (mode_t'(mode)),
        .advance (advance),
        .i_last  (i_last),
        .cw      (cw),
        .idle    (idle)
    );

    rc4_datapath #(
        .KEY_MAX (KEY_MAX)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cw         (cw),
        .advance    (advance),
        .accept     (accept),
        .key_index  (key_index),
        .byte_in    (byte_in),
        .key_length (key_length_reg),
        .i_last     (i_last),
        .crypt_byte (crypt_byte)
    );

    // Key length register: the user writes it only while idle; the block does not enforce this
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            key_length_reg <= LEN_W'(1);
        else if (cfg_wr_en)
            key_length_reg <= cfg_wr_data;
    end

    // Output beat: load on the final crypt step, drop once taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        priority if (cw.out_load && advance)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (cw.out_load && advance)
            byte_out_reg <= crypt_byte;
    end

    assign out_valid = out_valid_reg;
    assign byte_out  = byte_out_reg;

endmodule

FILE: rtl/rc4_sequencer.sv
// Step counter and control store lookup for the RC4 core.
module rc4_sequencer
    import rc4_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  accept,
    input  mode_t mode,
    input  logic  advance,
    input  logic  i_last,
    output cw_t   cw,
    output logic  idle
);

    upc_t upc_reg;
    upc_t upc_next;

    always_comb
    begin
        cw   = ucode_rom(upc_reg);
        idle = (upc_reg == UPC_IDLE);
    end

    always_comb
    begin
        upc_next = upc_reg;
        if (advance)
        begin
            unique case (cw.seq)
                SEQ_DISPATCH: upc_next = accept ? mode_entry(mode) : UPC_IDLE;
                SEQ_NEXT:     upc_next = upc_t'(upc_reg + 4'd1);
                SEQ_LOOP:     upc_next = i_last ? upc_t'(upc_reg + 4'd1) : cw.target;
                SEQ_DONE:     upc_next = UPC_IDLE;
                default:      upc_next = UPC_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            upc_reg <= UPC_IDLE;
        else
            upc_reg <= upc_next;
    end

endmodule

FILE: rtl/rc4_datapath.sv
// Permutation and key stores, pointers and keystream datapath of the RC4 core.
module rc4_datapath
    import rc4_pkg::*;
#(
    parameter int KEY_MAX = KEY_MAX_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  cw_t              cw,
    input  logic             advance,
    input  logic             accept,
    input  logic [7:0]       key_index,
    input  logic [7:0]       byte_in,
    input  logic [LEN_W-1:0] key_length,
    output logic             i_last,
    output logic [7:0]       crypt_byte
);

    localparam int KEY_AW = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;

    logic [7:0] perm_mem [0:255];
    logic [7:0] key_mem  [0:KEY_MAX-1];

    logic [7:0]        perm_rdata_reg;
    logic [7:0]        key_rdata_reg;
    logic [7:0]        i_reg, i_next;
    logic [7:0]        j_reg, j_next;
    logic [7:0]        a_reg;
    logic [7:0]        b_reg;
    logic [KEY_AW-1:0] k_reg, k_next;
    logic [7:0]        idx_reg;
    logic [7:0]        data_reg;

    logic [7:0]        j_sum;
    logic [7:0]        perm_raddr;
    logic [7:0]        perm_waddr;
    logic [7:0]        perm_wdata;
    logic [7:0]        ks_addr;
    logic [7:0]        ks_byte;
    logic [LEN_W-1:0]  eff_len;
    logic [LEN_W-1:0]  k_inc;
    logic              key_idx_ok;

    assign i_last  = (i_reg == 8'hFF);
    assign j_sum   = j_reg + perm_rdata_reg + (cw.j_use_key ? key_rdata_reg : 8'd0);
    assign k_inc   = LEN_W'(k_reg) + LEN_W'(1);
    assign ks_addr = a_reg + b_reg;
    assign key_idx_ok = ({1'b0, idx_reg} < LEN_W'(KEY_MAX));

    // Zero length acts as one; saturate at store depth
    always_comb
    begin
        priority if (key_length == '0)
            eff_len = LEN_W'(1);
        else if (key_length > LEN_W'(KEY_MAX))
            eff_len = LEN_W'(KEY_MAX);
        else
            eff_len = key_length;
    end

    always_comb
    begin
        unique case (cw.perm_rd_sel)
            RD_I:      perm_raddr = i_reg;
            RD_I_INC:  perm_raddr = i_reg + 8'd1;
            RD_J_SUM:  perm_raddr = j_sum;
            RD_A_PLUS: perm_raddr = a_reg + perm_rdata_reg;
            default:   perm_raddr = i_reg;
        endcase
        unique case (cw.perm_wa_sel)
            WA_I:    perm_waddr = i_reg;
            WA_J:    perm_waddr = j_reg;
            default: perm_waddr = i_reg;
        endcase
        unique case (cw.perm_wd_sel)
            WD_I:     perm_wdata = i_reg;
            WD_RDATA: perm_wdata = perm_rdata_reg;
            WD_A:     perm_wdata = a_reg;
            default:  perm_wdata = a_reg;
        endcase
    end

    // Keystream lookup was read before both swap writes landed: forward them
    always_comb
    begin
        priority if (ks_addr == j_reg)
            ks_byte = a_reg;
        else if (ks_addr == i_reg)
            ks_byte = b_reg;
        else
            ks_byte = perm_rdata_reg;
    end

    assign crypt_byte = data_reg ^ ks_byte;

    always_comb
    begin
        unique case (cw.i_op)
            I_HOLD:  i_next = i_reg;
            I_INC:   i_next = i_reg + 8'd1;
            I_CLR:   i_next = 8'd0;
            default: i_next = i_reg;
        endcase
        unique case (cw.j_op)
            J_HOLD:  j_next = j_reg;
            J_SUM:   j_next = j_sum;
            J_CLR:   j_next = 8'd0;
            default: j_next = j_reg;
        endcase
        unique case (cw.k_op)
            K_HOLD:  k_next = k_reg;
            K_CLR:   k_next = '0;
            K_STEP:  k_next = (k_inc >= eff_len) ? '0 : k_inc[KEY_AW-1:0];
            default: k_next = k_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_reg <= 8'd0;
            j_reg <= 8'd0;
            k_reg <= '0;
        end
        else if (advance)
        begin
            i_reg <= i_next;
            j_reg <= j_next;
            k_reg <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            idx_reg  <= key_index;
            data_reg <= byte_in;
        end
        if (advance && cw.a_load)
            a_reg <= perm_rdata_reg;
        if (advance && cw.b_load)
            b_reg <= perm_rdata_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance && cw.perm_we)
            perm_mem[perm_waddr] <= perm_wdata;
        if (advance && cw.perm_rd_en)
            perm_rdata_reg <= perm_mem[perm_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cw.key_we && key_idx_ok)
            key_mem[idx_reg[KEY_AW-1:0]] <= data_reg;
        key_rdata_reg <= key_mem[k_reg];
    end

endmodule
